// ===== hdl/lzbd_pkg.sv =====
// Shared types and constants of the LZ block decompressor.
// Depends on nothing; every other file imports it.
package lzbd_pkg;

    localparam int unsigned HISTORY_DEPTH   = 256;
    localparam int unsigned MAX_BLOCK_BYTES = 16384;

    localparam int unsigned HIST_AW   = $clog2(HISTORY_DEPTH);
    localparam int unsigned BLK_CW    = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned LANES     = 4;
    localparam int unsigned LANE_W    = $clog2(LANES);
    localparam int unsigned WORD_W    = 8 * LANES;
    localparam int unsigned COUNT_W   = $clog2(LANES + 1);

    localparam logic [BLK_CW-1:0] BLK_MAX = BLK_CW'(MAX_BLOCK_BYTES);

    typedef enum logic [1:0] {
        PH_TOKEN = 2'd0,
        PH_DIST  = 2'd1,
        PH_LIT   = 2'd2
    } lzbd_phase_t;

    typedef enum logic [1:0] {
        CODE_OK       = 2'd0,
        CODE_BAD_DIST = 2'd1,
        CODE_OVERFLOW = 2'd2,
        CODE_TRUNC    = 2'd3
    } lzbd_code_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_TOKEN,
        CMD_LITERAL,
        CMD_DIST_ERR,
        CMD_COPY_START,
        CMD_COPY_READ,
        CMD_COPY_WRITE,
        CMD_COPY_EMIT,
        CMD_TRUNC,
        CMD_CLEAR
    } lzbd_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_COPY_RD,
        S_COPY_WR,
        S_COPY_EMIT,
        S_END_CHK
    } lzbd_state_t;

    typedef struct packed {
        lzbd_phase_t phase;
        logic        blk_end;
        logic        slot_free;
        logic        dist_fail;
        logic        len_zero;
        logic        copy_flush;
        logic        copy_done;
    } lzbd_dp_stat_t;

endpackage

// ===== hdl/lzbd_if.sv =====
// Valid/ready channel interfaces for the compressed input and decoded output.
// Depends on lzbd_pkg for payload widths.
interface lzbd_in_if import lzbd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       block_end;

    modport source (output valid, output in_byte, output block_end, input ready);
    modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

interface lzbd_out_if import lzbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  out_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               run_last;
    logic [1:0]         status;

    modport source (output valid, output out_bytes, output byte_count,
                    output run_last, output status, input ready);
    modport sink   (input valid, input out_bytes, input byte_count,
                    input run_last, input status, output ready);
endinterface

// ===== hdl/lzbd_ctrl.sv =====
// Sequencer of the LZ block decompressor: one command to the datapath per cycle.
// Depends on lzbd_pkg.
module lzbd_ctrl import lzbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  lzbd_dp_stat_t stat,
    output logic          in_ready,
    output lzbd_cmd_t     cmd
);

    lzbd_state_t state_reg;
    lzbd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.phase)
                    PH_TOKEN: state_next = S_END_CHK;
                    PH_LIT:
                    begin
                        if (stat.slot_free)
                        begin
                            state_next = S_END_CHK;
                        end
                    end
                    PH_DIST:
                    begin
                        if (stat.dist_fail)
                        begin
                            if (stat.slot_free)
                            begin
                                state_next = S_END_CHK;
                            end
                        end
                        else if (stat.len_zero)
                        begin
                            state_next = S_END_CHK;
                        end
                        else
                        begin
                            state_next = S_COPY_RD;
                        end
                    end
                    default: state_next = S_END_CHK;
                endcase
            end
            S_COPY_RD: state_next = S_COPY_WR;
            S_COPY_WR:
            begin
                state_next = stat.copy_flush ? S_COPY_EMIT : S_COPY_RD;
            end
            S_COPY_EMIT:
            begin
                if (stat.slot_free)
                begin
                    state_next = stat.copy_done ? S_END_CHK : S_COPY_RD;
                end
            end
            S_END_CHK:
            begin
                if (!stat.blk_end || stat.phase == PH_TOKEN || stat.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = CMD_CAPTURE;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.phase)
                    PH_TOKEN: cmd = CMD_TOKEN;
                    PH_LIT:
                    begin
                        if (stat.slot_free)
                        begin
                            cmd = CMD_LITERAL;
                        end
                    end
                    PH_DIST:
                    begin
                        if (!stat.dist_fail)
                        begin
                            cmd = CMD_COPY_START;
                        end
                        else if (stat.slot_free)
                        begin
                            cmd = CMD_DIST_ERR;
                        end
                    end
                    default: cmd = CMD_NONE;
                endcase
            end
            S_COPY_RD: cmd = CMD_COPY_READ;
            S_COPY_WR: cmd = CMD_COPY_WRITE;
            S_COPY_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd = CMD_COPY_EMIT;
                end
            end
            S_END_CHK:
            begin
                if (stat.blk_end)
                begin
                    if (stat.phase == PH_TOKEN)
                    begin
                        cmd = CMD_CLEAR;
                    end
                    else if (stat.slot_free)
                    begin
                        cmd = CMD_TRUNC;
                    end
                end
            end
            default: cmd = CMD_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== hdl/lzbd_dp.sv =====
// Datapath of the LZ block decompressor: block state, history memory, output register.
// Depends on lzbd_pkg; driven by lzbd_ctrl commands.
module lzbd_dp import lzbd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lzbd_cmd_t          cmd,
    input  logic [7:0]         in_byte,
    input  logic               block_end,
    input  logic               out_ready,
    output lzbd_dp_stat_t      stat,
    output logic               out_valid,
    output logic [WORD_W-1:0]  out_bytes,
    output logic [COUNT_W-1:0] byte_count,
    output logic               run_last,
    output logic [1:0]         status
);

    logic [7:0]         hist_mem [HISTORY_DEPTH];
    logic [7:0]         rd_data_reg;

    logic [7:0]         byte_reg,      byte_next;
    logic               end_reg,       end_next;
    logic [HIST_AW-1:0] write_pos_reg, write_pos_next;
    logic [BLK_CW-1:0]  bytes_reg,     bytes_next;
    lzbd_phase_t        phase_reg,     phase_next;
    logic [LEN_W-1:0]   run_left_reg,  run_left_next;
    logic [LEN_W-1:0]   match_len_reg, match_len_next;
    logic [LEN_W-1:0]   copy_left_reg, copy_left_next;
    logic [WORD_W-1:0]  word_reg,      word_next;
    logic [COUNT_W-1:0] cnt_reg,       cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  obytes_reg,    obytes_next;
    logic [COUNT_W-1:0] ocount_reg,    ocount_next;
    logic               olast_reg,     olast_next;
    lzbd_code_t         ocode_reg,     ocode_next;

    logic               wr_en;
    logic [7:0]         wr_data;
    logic [HIST_AW-1:0] rd_addr;
    logic               dist_bad;
    logic               dist_ovf;
    logic               slot_free;
    logic               lit_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign rd_addr   = write_pos_reg - HIST_AW'(byte_reg);
    assign dist_bad  = (byte_reg == 8'd0) || (BLK_CW'(byte_reg) > bytes_reg);
    assign dist_ovf  = ({1'b0, bytes_reg} + (BLK_CW + 1)'(match_len_reg)) > {1'b0, BLK_MAX};
    assign lit_last  = (run_left_reg == LEN_W'(1));

    assign stat.phase      = phase_reg;
    assign stat.blk_end    = end_reg;
    assign stat.slot_free  = slot_free;
    assign stat.dist_fail  = dist_bad || dist_ovf;
    assign stat.len_zero   = (match_len_reg == '0);
    assign stat.copy_flush = (cnt_reg == COUNT_W'(LANES - 1)) || (copy_left_reg == LEN_W'(1));
    assign stat.copy_done  = (copy_left_reg == '0);

    always_comb
    begin
        byte_next      = byte_reg;
        end_next       = end_reg;
        write_pos_next = write_pos_reg;
        bytes_next     = bytes_reg;
        phase_next     = phase_reg;
        run_left_next  = run_left_reg;
        match_len_next = match_len_reg;
        copy_left_next = copy_left_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        wr_data        = rd_data_reg;

        out_valid_next = out_valid_reg && !out_ready;
        obytes_next    = obytes_reg;
        ocount_next    = ocount_reg;
        olast_next     = olast_reg;
        ocode_next     = ocode_reg;

        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_CAPTURE:
            begin
                byte_next = in_byte;
                end_next  = block_end;
            end
            CMD_TOKEN:
            begin
                if (byte_reg[0])
                begin
                    match_len_next = byte_reg[7:1];
                    phase_next     = PH_DIST;
                end
                else
                begin
                    run_left_next = byte_reg[7:1];
                    phase_next    = (byte_reg[7:1] != '0) ? PH_LIT : PH_TOKEN;
                end
            end
            CMD_LITERAL:
            begin
                run_left_next  = run_left_reg - LEN_W'(1);
                out_valid_next = 1'b1;
                olast_next     = lit_last;
                if (lit_last)
                begin
                    phase_next = PH_TOKEN;
                end
                if (bytes_reg >= BLK_MAX)
                begin
                    // past the block limit: consume, do not store
                    obytes_next = '0;
                    ocount_next = '0;
                    ocode_next  = CODE_OVERFLOW;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = byte_reg;
                    write_pos_next = write_pos_reg + HIST_AW'(1);
                    bytes_next     = bytes_reg + BLK_CW'(1);
                    obytes_next    = WORD_W'(byte_reg);
                    ocount_next    = COUNT_W'(1);
                    ocode_next     = CODE_OK;
                end
            end
            CMD_DIST_ERR:
            begin
                phase_next     = PH_TOKEN;
                match_len_next = '0;
                out_valid_next = 1'b1;
                obytes_next    = '0;
                ocount_next    = '0;
                olast_next     = 1'b1;
                ocode_next     = dist_bad ? CODE_BAD_DIST : CODE_OVERFLOW;
            end
            CMD_COPY_START:
            begin
                copy_left_next = match_len_reg;
                word_next      = '0;
                cnt_next       = '0;
                phase_next     = PH_TOKEN;
                match_len_next = '0;
            end
            CMD_COPY_READ:
            begin
            end
            CMD_COPY_WRITE:
            begin
                wr_en          = 1'b1;
                write_pos_next = write_pos_reg + HIST_AW'(1);
                bytes_next     = bytes_reg + BLK_CW'(1);
                word_next[cnt_reg[LANE_W-1:0]*8 +: 8] = rd_data_reg;
                cnt_next       = cnt_reg + COUNT_W'(1);
                copy_left_next = copy_left_reg - LEN_W'(1);
            end
            CMD_COPY_EMIT:
            begin
                out_valid_next = 1'b1;
                obytes_next    = word_reg;
                ocount_next    = cnt_reg;
                olast_next     = (copy_left_reg == '0);
                ocode_next     = CODE_OK;
                word_next      = '0;
                cnt_next       = '0;
            end
            CMD_TRUNC:
            begin
                out_valid_next = 1'b1;
                obytes_next    = '0;
                ocount_next    = '0;
                olast_next     = 1'b1;
                ocode_next     = CODE_TRUNC;
                write_pos_next = '0;
                bytes_next     = '0;
                phase_next     = PH_TOKEN;
                run_left_next  = '0;
                match_len_next = '0;
            end
            CMD_CLEAR:
            begin
                write_pos_next = '0;
                bytes_next     = '0;
                phase_next     = PH_TOKEN;
                run_left_next  = '0;
                match_len_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // history memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[write_pos_reg] <= wr_data;
        end
        if (cmd == CMD_COPY_READ)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg       <= 1'b0;
            write_pos_reg <= '0;
            bytes_reg     <= '0;
            phase_reg     <= PH_TOKEN;
            run_left_reg  <= '0;
            match_len_reg <= '0;
            copy_left_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            end_reg       <= end_next;
            write_pos_reg <= write_pos_next;
            bytes_reg     <= bytes_next;
            phase_reg     <= phase_next;
            run_left_reg  <= run_left_next;
            match_len_reg <= match_len_next;
            copy_left_reg <= copy_left_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        word_reg   <= word_next;
        obytes_reg <= obytes_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
        ocode_reg  <= ocode_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_bytes  = obytes_reg;
    assign byte_count = ocount_reg;
    assign run_last   = olast_reg;
    assign status     = ocode_reg;

endmodule

// ===== hdl/lz_block_decompressor.sv =====
// Top level of the LZ block decompressor: sequencer plus datapath.
// Depends on lzbd_pkg, lzbd_if, lzbd_ctrl and lzbd_dp.
//
//   channel     | dir | payload                                  | handshake
//   ------------+-----+------------------------------------------+----------
//   compressed  | in  | in_byte[7:0], block_end                  | valid/ready
//   decoded     | out | out_bytes[31:0], byte_count[2:0],        | valid/ready
//               |     | run_last, status[1:0]                    |
//
// Each compressed word is taken in the idle state and held for the whole of
// its work, so one word is in flight at a time. A match distance word copies
// each byte in a read step and then a write step, a split set by the history
// memory's registered read, which must see the byte written just before it
// when the distance is one; the copied bytes leave in packed output words.
// Reset (rst_n, asynchronous, active low) leaves the block expecting a token
// with an empty history; no clearing pass is needed, since a valid distance
// only reaches bytes written in the current block.
// A single output register holds the next decoded word; the block accepts
// new compressed words while it waits and stalls only when a second result
// is due before the decoded side takes the first.
module lz_block_decompressor import lzbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lzbd_in_if.sink     compressed,
    lzbd_out_if.source  decoded
);

    lzbd_cmd_t     cmd;
    lzbd_dp_stat_t stat;

    // sequencer: advance through token, literal, distance and copy steps
    lzbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (compressed.valid),
        .stat     (stat),
        .in_ready (compressed.ready),
        .cmd      (cmd)
    );

    // datapath: hold block state and history, drive the decoded word
    lzbd_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_byte    (compressed.in_byte),
        .block_end  (compressed.block_end),
        .out_ready  (decoded.ready),
        .stat       (stat),
        .out_valid  (decoded.valid),
        .out_bytes  (decoded.out_bytes),
        .byte_count (decoded.byte_count),
        .run_last   (decoded.run_last),
        .status     (decoded.status)
    );

endmodule

// ===== dv/lzbd_decode_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the LZ block decompressor: watches both channels, decodes
// each accepted compressed word itself and compares every decoded word.
// Depends on lzbd_pkg and the channel interfaces in lzbd_if.
module lzbd_decode_checker import lzbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lzbd_in_if     compressed,
    lzbd_out_if    decoded,
    output int     pending,
    output int     failures,
    output int     checked
);

    localparam int unsigned PRINT_CAP = 30;
    localparam int unsigned EXP_DEPTH = 64;    // one word in flight: at most 33 outstanding
    localparam int unsigned EXP_AW    = $clog2(EXP_DEPTH);

    typedef struct {
        logic [WORD_W-1:0]  out_bytes;
        logic [COUNT_W-1:0] byte_count;
        logic               run_last;
        lzbd_code_t         status;
    } decoded_word_t;

    decoded_word_t     expected_words [EXP_DEPTH];
    logic [EXP_AW-1:0] exp_head;
    logic [EXP_AW-1:0] exp_tail;
    int unsigned       exp_count;

    logic [7:0]        history [HISTORY_DEPTH];
    logic [HIST_AW-1:0] wr_pos;
    int unsigned       block_bytes;
    lzbd_phase_t       dec_phase;
    logic [LEN_W-1:0]  run_left;
    logic [LEN_W-1:0]  match_len;
    int unsigned       n_fail;
    int unsigned       n_checked;

    task automatic report_mismatch(input string what);
        if (n_fail < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        n_fail++;
    endtask

    function automatic void queue_word(input logic [WORD_W-1:0] bytes,
                                       input int unsigned cnt, input logic last,
                                       input lzbd_code_t code);
        decoded_word_t w;
        w.out_bytes  = bytes;
        w.byte_count = COUNT_W'(cnt);
        w.run_last   = last;
        w.status     = code;
        expected_words[exp_tail] = w;
        exp_tail  = exp_tail + 1'b1;
        exp_count++;
    endfunction

    function automatic void keep_byte(input logic [7:0] v);
        history[wr_pos] = v;
        wr_pos++;
        block_bytes++;
    endfunction

    function automatic void clear_block();
        wr_pos      = '0;
        block_bytes = 0;
        dec_phase   = PH_TOKEN;
        run_left    = '0;
        match_len   = '0;
    endfunction

    // Work out the decoded words that one compressed word gives rise to.
    function automatic void decode_word(input logic [7:0] b, input logic blk_end);
        int unsigned       back;
        int unsigned       n;
        int unsigned       cnt;
        logic [WORD_W-1:0] acc;
        logic [7:0]        v;
        logic [HIST_AW-1:0] src;
        logic              last;
        case (dec_phase)
            PH_DIST:
            begin
                back      = b;
                n         = match_len;
                dec_phase = PH_TOKEN;
                match_len = '0;
                if (back == 0 || back > block_bytes)
                    queue_word('0, 0, 1'b1, CODE_BAD_DIST);
                else if (block_bytes + n > MAX_BLOCK_BYTES)
                    queue_word('0, 0, 1'b1, CODE_OVERFLOW);
                else
                begin
                    cnt = 0;
                    acc = '0;
                    // copy byte by byte so an overlapping source sees fresh bytes
                    for (int i = 0; i < n; i++)
                    begin
                        src = wr_pos - HIST_AW'(back);
                        v   = history[src];
                        keep_byte(v);
                        acc = acc | (WORD_W'(v) << (8 * cnt));
                        cnt++;
                        if (cnt == LANES || i == n - 1)
                        begin
                            queue_word(acc, cnt, i == n - 1, CODE_OK);
                            acc = '0;
                            cnt = 0;
                        end
                    end
                end
            end
            PH_LIT:
            begin
                run_left = run_left - 1'b1;
                last     = (run_left == 0);
                if (block_bytes >= MAX_BLOCK_BYTES)
                    queue_word('0, 0, last, CODE_OVERFLOW);
                else
                begin
                    keep_byte(b);
                    queue_word(WORD_W'(b), 1, last, CODE_OK);
                end
                if (last)
                    dec_phase = PH_TOKEN;
            end
            default:
            begin
                if (b[0])
                begin
                    match_len = b[7:1];
                    dec_phase = PH_DIST;
                end
                else
                begin
                    run_left  = b[7:1];
                    dec_phase = (b[7:1] != 0) ? PH_LIT : PH_TOKEN;
                end
            end
        endcase
        if (blk_end)
        begin
            if (dec_phase != PH_TOKEN)
                queue_word('0, 0, 1'b1, CODE_TRUNC);
            clear_block();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_word_t want;
        if (!rst_n)
        begin
            exp_head  = '0;
            exp_tail  = '0;
            exp_count = 0;
            clear_block();
            n_fail    = 0;
            n_checked = 0;
            pending  <= 0;
            failures <= 0;
            checked  <= 0;
        end
        else
        begin
            // compare first: a word leaving now cannot stem from a word entering now
            if (decoded.valid && decoded.ready)
            begin
                n_checked++;
                if (exp_count == 0)
                    report_mismatch($sformatf("unexpected word %h count %0d last %0d status %0d",
                        decoded.out_bytes, decoded.byte_count, decoded.run_last,
                        decoded.status));
                else
                begin
                    want      = expected_words[exp_head];
                    exp_head  = exp_head + 1'b1;
                    exp_count--;
                    if (decoded.out_bytes !== want.out_bytes)
                        report_mismatch($sformatf("out_bytes %h, want %h",
                            decoded.out_bytes, want.out_bytes));
                    if (decoded.byte_count !== want.byte_count)
                        report_mismatch($sformatf("byte_count %0d, want %0d",
                            decoded.byte_count, want.byte_count));
                    if (decoded.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %0d, want %0d",
                            decoded.run_last, want.run_last));
                    if (decoded.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            decoded.status, want.status));
                end
            end
            if (compressed.valid && compressed.ready)
                decode_word(compressed.in_byte, compressed.block_end);
            pending  <= int'(exp_count);
            failures <= int'(n_fail);
            checked  <= int'(n_checked);
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Top of the LZ block decompressor testbench: clock, reset, stimulus, verdict.
// Depends on lzbd_pkg, lzbd_if, the block itself and lzbd_decode_checker.
module tb;
    import lzbd_pkg::*;

    localparam int unsigned ITEM_TARGET  = 380;     // compressed words in all, directed part included
    localparam int unsigned QUIET_ITEMS  = 40;      // final stretch with no idling at all
    localparam int unsigned OVF_AT       = 60;      // start of the block that fills up
    localparam int unsigned TAIL_CYCLES  = 400;     // longer than the longest match takes to decode
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam logic        KIND_LIT     = 1'b0;
    localparam logic        KIND_MATCH   = 1'b1;

    logic        clk;
    logic        rst_n;

    int          pending;
    int          failures;
    int          checked;

    int unsigned n_items;
    int unsigned n_blocks;
    int unsigned blk_bytes;     // decoded bytes so far in the current block
    int unsigned idle_odds;     // 0: no idling; else one chance in idle_odds of a gap before each word or a ready stall
    bit          ovf_done;

    lzbd_in_if  compressed ();
    lzbd_out_if decoded ();

    lz_block_decompressor i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .compressed (compressed),
        .decoded    (decoded)
    );

    lzbd_decode_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .compressed (compressed),
        .decoded    (decoded),
        .pending    (pending),
        .failures   (failures),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles with %0d words still expected", CYCLE_LIMIT, pending);
        $display("Test completed with failures");
        $finish;
    end

    // Decoded side: drop ready in random bursts, at the current odds.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        decoded.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                decoded.ready <= 1'b0;
            else if (stall_left != 0)
                stall_left--;
            else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
            begin
                decoded.ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
                decoded.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] token(input logic kind, input int unsigned len);
        return {7'(len), kind};
    endfunction

    // A distance within this block's bytes, short ones often for overlap; any when the block is empty.
    function automatic logic [7:0] near_dist();
        int unsigned reach;
        reach = (blk_bytes > 255) ? 255 : blk_bytes;
        if (reach == 0)
            return 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(1, (reach > 4) ? 4 : reach));
        return 8'($urandom_range(1, reach));
    endfunction

    // Present one compressed word and hold it until the block takes it.
    // Valid stays high into the next word unless a gap is inserted.
    task automatic send_word(input logic [7:0] b, input logic blk_end);
        if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
        begin
            compressed.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        compressed.valid     <= 1'b1;
        compressed.in_byte   <= b;
        compressed.block_end <= blk_end;
        @(posedge clk);
        while (!compressed.ready)
            @(posedge clk);
        n_items++;
        if (blk_end)
            n_blocks++;
    endtask

    // Hold off the sender until every expected decoded word has come out.
    task automatic drain();
        compressed.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Block of literal runs and matches, now and then with a bad distance or cut short.
    task automatic random_block();
        int unsigned n_tok;
        int unsigned len;
        int unsigned sent;
        int unsigned pick;
        bit          last_tok;
        bit          cut;
        bit          is_match;
        logic [7:0]  dist_byte;
        n_tok     = $urandom_range(1, 6);
        blk_bytes = 0;
        for (int t = 0; t < n_tok; t++)
        begin
            last_tok = (t == n_tok - 1);
            cut      = last_tok && ($urandom_range(0, 5) == 0);
            is_match = ($urandom_range(0, 7) < ((blk_bytes != 0) ? 4 : 1));
            if (is_match)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 16);
                send_word(token(KIND_MATCH, len), cut);
                if (!cut)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        dist_byte = 8'd0;
                    else if (pick == 1 && blk_bytes < 255)
                        dist_byte = 8'($urandom_range(blk_bytes + 1, 255));
                    else
                        dist_byte = near_dist();
                    send_word(dist_byte, last_tok);
                    if (dist_byte != 0 && dist_byte <= blk_bytes)
                        blk_bytes += len;
                end
            end
            else
            begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
                if (cut && len == 0)
                    len = $urandom_range(1, 8);
                sent = cut ? $urandom_range(0, len - 1) : len;
                send_word(token(KIND_LIT, len), last_tok && sent == 0);
                for (int i = 0; i < sent; i++)
                    send_word(8'($urandom), last_tok && i == sent - 1);
                blk_bytes += sent;
            end
        end
    endtask

    // Raw bytes; always close the block so the next one starts clean.
    task automatic noise_burst();
        int unsigned n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_word(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
        blk_bytes = 0;
    endtask

    // Fill a block to its byte limit with long matches, then push past it
    // with a match and a literal run, with a zero-length match between them.
    task automatic overflow_block();
        int unsigned head;
        int unsigned room;
        int unsigned len;
        head = $urandom_range(1, 8);
        send_word(token(KIND_LIT, head), 1'b0);
        repeat (head) send_word(8'($urandom), 1'b0);
        blk_bytes = head;
        while (blk_bytes + 127 <= MAX_BLOCK_BYTES)
        begin
            send_word(token(KIND_MATCH, 127), 1'b0);
            send_word(near_dist(), 1'b0);
            blk_bytes += 127;
        end
        room = MAX_BLOCK_BYTES - blk_bytes;
        if (room != 0)
        begin
            send_word(token(KIND_MATCH, room), 1'b0);
            send_word(near_dist(), 1'b0);
            blk_bytes += room;
        end
        // block now exactly full
        send_word(token(KIND_MATCH, $urandom_range(1, 127)), 1'b0);
        send_word(near_dist(), 1'b0);
        send_word(token(KIND_MATCH, 0), 1'b0);
        send_word(near_dist(), 1'b0);
        len = $urandom_range(1, 4);
        send_word(token(KIND_LIT, len), 1'b0);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), i == len - 1);
        blk_bytes = 0;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        compressed.valid     <= 1'b0;
        compressed.in_byte   <= '0;
        compressed.block_end <= 1'b0;
        n_items   = 0;
        n_blocks  = 0;
        blk_bytes = 0;
        ovf_done  = 1'b0;
        idle_odds = 4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty literal run, byte extremes, empty match, zero distance, longest overlapping
        // copy, distance beyond the block, short overlap, a block end, then truncation on a match token,
        // a reach into the last block's history, truncation mid-run and truncation on a literal token.
        send_word(token(KIND_LIT, 0), 1'b0);
        send_word(token(KIND_LIT, 2), 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(token(KIND_MATCH, 0), 1'b0);
        send_word(8'd1, 1'b0);
        send_word(token(KIND_MATCH, 3), 1'b0);
        send_word(8'd0, 1'b0);
        send_word(token(KIND_MATCH, 127), 1'b0);
        send_word(8'd1, 1'b0);
        send_word(token(KIND_MATCH, 4), 1'b0);
        send_word(8'd200, 1'b0);                    // only 129 bytes so far
        send_word(token(KIND_MATCH, 5), 1'b0);
        send_word(8'd3, 1'b0);
        send_word(token(KIND_LIT, 1), 1'b0);
        send_word(8'hAA, 1'b1);
        send_word(token(KIND_MATCH, 9), 1'b1);      // distance still due
        send_word(token(KIND_MATCH, 2), 1'b0);      // history of the last block is off limits
        send_word(8'd1, 1'b0);
        send_word(token(KIND_LIT, 3), 1'b0);
        send_word(8'h5A, 1'b1);                     // two literal bytes still due
        send_word(token(KIND_LIT, 6), 1'b1);
        drain();

        // Random: mostly well-formed blocks, some noise, one block run to its limit.
        while (n_items < ITEM_TARGET)
        begin
            if (n_items + QUIET_ITEMS >= ITEM_TARGET)
                idle_odds = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 3;
                    default: idle_odds = 6;
                endcase
            end
            if (!ovf_done && n_items >= OVF_AT)
            begin
                overflow_block();
                ovf_done = 1'b1;
                drain();
            end
            else if ($urandom_range(0, 6) == 0)
                noise_burst();
            else
                random_block();
        end

        idle_odds = 0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d decoded words from %0d compressed words in %0d blocks,",
                 checked, n_items, n_blocks);
        $display("covering all four status codes and one block filled to %0d bytes.",
                 MAX_BLOCK_BYTES);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lzbd_pkg.sv
hdl/lzbd_if.sv
hdl/lzbd_ctrl.sv
hdl/lzbd_dp.sv
hdl/lz_block_decompressor.sv
dv/lzbd_decode_checker.sv
dv/tb.sv
